// File: rtl/brbd_pkg.sv
// brbd_pkg: shared types and constants of the byte ring buffer deque
`timescale 1ns / 1ps
`default_nettype none
package brbd_pkg;

  localparam int unsigned DEPTH_DEF = 256;
  localparam int unsigned CAP_W     = 9;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned OP_W      = 3;

  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 3'd0,
    OP_PULL   = 3'd1,
    OP_POP    = 3'd2,
    OP_FLUSH  = 3'd3,
    OP_STATUS = 3'd4
  } op_t;

endpackage
`default_nettype wire

// File: rtl/byte_ring_buffer_deque.sv
// byte_ring_buffer_deque: circular byte buffer with push, pull, pop, flush and status
//
// usage
//   input channel in_valid / in_stall carries in_opcode and in_data_in; an item is taken at
//   an edge with in_valid high and in_stall low
//   result channel out_valid / out_stall carries ok, the removed byte, count, free space and
//   the empty and full flags after the operation
//   cfg_wr_en / cfg_wr_data set the capacity (0 acts as 1, above DEPTH acts as DEPTH) and
//   flush the buffer; write only while no result is outstanding
// timing
//   the result of an item appears one cycle after it is taken, from the output register and
//   the registered read port of the byte memory
//   one item per cycle is sustained while the receiver takes results; pointer update and
//   memory write or read all happen at the edge that takes the item
// reset and stall
//   reset empties the buffer (head and tail at zero) and sets the capacity to 256; memory
//   contents are not cleared, so no clearing pass is needed
//   while a result waits under out_stall, in_stall is raised and the result holds
`timescale 1ns / 1ps
`default_nettype none
module byte_ring_buffer_deque #(
  parameter int unsigned DEPTH = brbd_pkg::DEPTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [brbd_pkg::OP_W-1:0]   in_opcode,
  input  wire logic [brbd_pkg::BYTE_W-1:0] in_data_in,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_ok,
  output logic      [brbd_pkg::BYTE_W-1:0] out_data_out,
  output logic      [brbd_pkg::CAP_W-1:0]  out_count,
  output logic      [brbd_pkg::CAP_W-1:0]  out_free_space,
  output logic                             out_is_empty,
  output logic                             out_is_full,
  input  wire logic                        cfg_wr_en,
  input  wire logic [brbd_pkg::CAP_W-1:0]  cfg_wr_data
);

  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = (AW + 1 > brbd_pkg::CAP_W) ? AW + 1 : brbd_pkg::CAP_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  logic [brbd_pkg::CAP_W-1:0] capacity_r;
  logic [AW-1:0]              head_r, head_nxt;
  logic [AW-1:0]              tail_r, tail_nxt;
  logic                       empty_r, empty_nxt;

  logic                       out_valid_r;
  logic                       ok_r, ok_nxt;
  logic                       rd_taken_r;
  logic [brbd_pkg::CAP_W-1:0] count_r, count_nxt;
  logic [brbd_pkg::CAP_W-1:0] free_r, free_nxt;
  logic                       is_empty_r;
  logic                       is_full_r, full_nxt;

  logic [CW-1:0]               cap_u;
  logic [CW-1:0]               cap_ext;
  logic [CW-1:0]               head_inc, tail_inc;
  logic [CW-1:0]               cnt_w;
  logic                        full_now;
  logic                        accept;
  logic                        wr_en, rd_en;
  logic [AW-1:0]               rd_addr;
  logic [brbd_pkg::BYTE_W-1:0] rd_data_r;

  // capacity in use and wrap of the indices
  always_comb begin
    cap_ext = CW'(capacity_r);
    if (capacity_r == '0) begin
      cap_u = CW'(1);
    end else if (cap_ext > DEPTH_C) begin
      cap_u = DEPTH_C;
    end else begin
      cap_u = cap_ext;
    end
  end

  assign head_inc = CW'(head_r) + CW'(1);
  assign tail_inc = CW'(tail_r) + CW'(1);
  assign full_now = !empty_r && (head_r == tail_r);
  assign accept   = in_valid && !in_stall;
  assign in_stall = out_valid_r && out_stall;

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    empty_nxt = empty_r;
    ok_nxt = 1'b0;
    wr_en = 1'b0;
    rd_en = 1'b0;
    rd_addr = head_r;
    unique case (in_opcode)
      brbd_pkg::OP_PUSH: begin
        if (!full_now) begin
          if (empty_r) begin
            head_nxt = tail_r;
          end
          empty_nxt = 1'b0;
          tail_nxt = (tail_inc >= cap_u) ? '0 : tail_inc[AW-1:0];
          wr_en = accept;
          ok_nxt = 1'b1;
        end
      end
      brbd_pkg::OP_PULL: begin
        if (!empty_r) begin
          head_nxt = (head_inc >= cap_u) ? '0 : head_inc[AW-1:0];
          empty_nxt = (head_nxt == tail_r);
          rd_en = accept;
          rd_addr = head_r;
          ok_nxt = 1'b1;
        end
      end
      brbd_pkg::OP_POP: begin
        if (!empty_r) begin
          tail_nxt = (tail_r == '0) ? AW'(cap_u - CW'(1)) : tail_r - AW'(1);
          empty_nxt = (head_r == tail_nxt);
          rd_en = accept;
          rd_addr = tail_nxt;
          ok_nxt = 1'b1;
        end
      end
      brbd_pkg::OP_FLUSH: begin
        head_nxt = '0;
        tail_nxt = '0;
        empty_nxt = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // status after the operation
  always_comb begin
    full_nxt = !empty_nxt && (head_nxt == tail_nxt);
    if (empty_nxt) begin
      cnt_w = '0;
    end else if (head_nxt == tail_nxt) begin
      cnt_w = cap_u;
    end else if (head_nxt < tail_nxt) begin
      cnt_w = CW'(tail_nxt) - CW'(head_nxt);
    end else begin
      cnt_w = cap_u - (CW'(head_nxt) - CW'(tail_nxt));
    end
    count_nxt = cnt_w[brbd_pkg::CAP_W-1:0];
    free_nxt = brbd_pkg::CAP_W'(cap_u - cnt_w);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= brbd_pkg::CAP_RESET;
      head_r <= '0;
      tail_r <= '0;
      empty_r <= 1'b1;
    end else if (cfg_wr_en) begin
      capacity_r <= cfg_wr_data;
      head_r <= '0;
      tail_r <= '0;
      empty_r <= 1'b1;
    end else if (accept) begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      empty_r <= empty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ok_r <= ok_nxt;
      rd_taken_r <= rd_en;
      count_r <= count_nxt;
      free_r <= free_nxt;
      is_empty_r <= empty_nxt;
      is_full_r <= full_nxt;
    end
  end

  brbd_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (tail_r),
    .wr_data   (in_data_in),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data_r)
  );

  // only a pull or pop that took a byte drives the data
  assign out_valid      = out_valid_r;
  assign out_ok         = ok_r;
  assign out_data_out   = rd_taken_r ? rd_data_r : '0;
  assign out_count      = count_r;
  assign out_free_space = free_r;
  assign out_is_empty   = is_empty_r;
  assign out_is_full    = is_full_r;

`ifndef NO_ASSERTIONS
  a_idx_below_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (CW'(head_r) < cap_u) && (CW'(tail_r) < cap_u))
    else $error("ring index beyond capacity in use");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("taken item left no result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !accept)
    else $error("item taken while result waits");

  a_empty_full_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(is_empty_r && is_full_r))
    else $error("result both empty and full");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (is_empty_r == (count_r == '0)))
    else $error("empty flag disagrees with count");
`endif

endmodule
`default_nettype wire

// File: rtl/brbd_ram.sv
// brbd_ram: byte storage with one write port and one registered read port
`timescale 1ns / 1ps
`default_nettype none
module brbd_ram #(
  parameter int unsigned DEPTH = brbd_pkg::DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic                        clk,
  input  wire logic                        wr_en,
  input  wire logic [AW-1:0]               wr_addr,
  input  wire logic [brbd_pkg::BYTE_W-1:0] wr_data,
  input  wire logic                        rd_en,
  input  wire logic [AW-1:0]               rd_addr,
  output logic      [brbd_pkg::BYTE_W-1:0] rd_data_r
);

  logic [brbd_pkg::BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// File: sim/testbench.sv
// testbench: self-checking bench for byte_ring_buffer_deque with its own ring buffer predictor
`timescale 1ns / 1ps
module testbench;

  localparam int RING_DEPTH      = brbd_pkg::DEPTH_DEF;
  localparam int IDX_W           = $clog2(RING_DEPTH);
  localparam int OP_CODES        = 2 ** brbd_pkg::OP_W;
  localparam int RESET_CYCLES    = 7;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int WATCHDOG_LIMIT  = 5000;

  typedef struct packed {
    logic                        ok;
    logic [brbd_pkg::BYTE_W-1:0] data_out;
    logic [brbd_pkg::CAP_W-1:0]  count;
    logic [brbd_pkg::CAP_W-1:0]  free_space;
    logic                        is_empty;
    logic                        is_full;
  } ring_result_t;

  logic                        clk         = 1'b0;
  logic                        rst_n       = 1'b0;
  logic                        in_valid    = 1'b0;
  logic [brbd_pkg::OP_W-1:0]   in_opcode   = '0;
  logic [brbd_pkg::BYTE_W-1:0] in_data_in  = '0;
  logic                        out_stall   = 1'b0;
  logic                        cfg_wr_en   = 1'b0;
  logic [brbd_pkg::CAP_W-1:0]  cfg_wr_data = '0;
  logic                        in_stall;
  logic                        out_valid;
  logic                        out_ok;
  logic [brbd_pkg::BYTE_W-1:0] out_data_out;
  logic [brbd_pkg::CAP_W-1:0]  out_count;
  logic [brbd_pkg::CAP_W-1:0]  out_free_space;
  logic                        out_is_empty;
  logic                        out_is_full;

  // predicted buffer state
  logic [brbd_pkg::BYTE_W-1:0] ring_cells [RING_DEPTH];
  logic [IDX_W-1:0]            ring_head     = '0;
  logic [IDX_W-1:0]            ring_tail     = '0;
  logic                        ring_empty    = 1'b1;
  logic [brbd_pkg::CAP_W-1:0]  ring_capacity = brbd_pkg::CAP_RESET;

  ring_result_t pending_results[$];
  int           fail_count    = 0;
  int           idle_cycles   = 0;
  int           in_idle_pct   = 0;
  int           out_stall_pct = 0;
  bit           hold_off_req  = 1'b0;

  byte_ring_buffer_deque #(.DEPTH(RING_DEPTH)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_data_in     (in_data_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_ok         (out_ok),
    .out_data_out   (out_data_out),
    .out_count      (out_count),
    .out_free_space (out_free_space),
    .out_is_empty   (out_is_empty),
    .out_is_full    (out_is_full),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  always #2 clk = ~clk;

  function automatic int capacity_in_use();
    if (ring_capacity == 0) return 1;
    if (ring_capacity > RING_DEPTH) return RING_DEPTH;
    return ring_capacity;
  endfunction

  function automatic logic [IDX_W-1:0] ring_advance(logic [IDX_W-1:0] idx, int cap);
    return (int'(idx) + 1 >= cap) ? '0 : idx + 1'b1;
  endfunction

  function automatic void ring_flush();
    ring_head  = '0;
    ring_tail  = '0;
    ring_empty = 1'b1;
  endfunction

  function automatic ring_result_t ring_apply_op(logic [brbd_pkg::OP_W-1:0] op,
                                                 logic [brbd_pkg::BYTE_W-1:0] din);
    ring_result_t res;
    int           cap;
    int           held;
    res = '0;
    cap = capacity_in_use();
    case (op)
      brbd_pkg::OP_PUSH: begin
        if (ring_empty || ring_head != ring_tail) begin
          if (ring_empty) begin
            ring_head  = ring_tail;
            ring_empty = 1'b0;
          end
          ring_cells[ring_tail] = din;
          ring_tail = ring_advance(ring_tail, cap);
          res.ok = 1'b1;
        end
      end
      brbd_pkg::OP_PULL: begin
        if (!ring_empty) begin
          res.data_out = ring_cells[ring_head];
          ring_head = ring_advance(ring_head, cap);
          if (ring_head == ring_tail) ring_empty = 1'b1;
          res.ok = 1'b1;
        end
      end
      brbd_pkg::OP_POP: begin
        if (!ring_empty) begin
          ring_tail = (ring_tail == 0) ? IDX_W'(cap - 1) : ring_tail - 1'b1;
          if (ring_head == ring_tail) ring_empty = 1'b1;
          res.data_out = ring_cells[ring_tail];
          res.ok = 1'b1;
        end
      end
      brbd_pkg::OP_FLUSH: ring_flush();
      default: ;
    endcase
    if (ring_empty) held = 0;
    else if (ring_head == ring_tail) held = cap;
    else if (ring_head < ring_tail) held = ring_tail - ring_head;
    else held = cap - (ring_head - ring_tail);
    res.count      = brbd_pkg::CAP_W'(held);
    res.free_space = brbd_pkg::CAP_W'(cap - held);
    res.is_empty   = ring_empty;
    res.is_full    = !ring_empty && ring_head == ring_tail;
    return res;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    ring_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with no item outstanding");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("ok", want.ok, out_ok);
        check_field("data_out", want.data_out, out_data_out);
        check_field("count", want.count, out_count);
        check_field("free_space", want.free_space, out_free_space);
        check_field("is_empty", want.is_empty, out_is_empty);
        check_field("is_full", want.is_full, out_is_full);
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver stall, with an occasional long hold-off
  initial begin
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end
      out_stall = ($urandom_range(99) < out_stall_pct);
    end
  end

  task automatic send_item(logic [brbd_pkg::OP_W-1:0] op, logic [brbd_pkg::BYTE_W-1:0] din);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    in_opcode  = op;
    in_data_in = din;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(ring_apply_op(op, din));
    @(negedge clk);
  endtask

  task automatic wait_results_drained();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_capacity(logic [brbd_pkg::CAP_W-1:0] value);
    wait_results_drained();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    ring_capacity = value;
    ring_flush();
  endtask

  function automatic logic [brbd_pkg::OP_W-1:0] pick_op(int push_pct);
    int r;
    r = $urandom_range(99);
    if (r < push_pct) return brbd_pkg::OP_PUSH;
    r = $urandom_range(99);
    if (r < 45) return brbd_pkg::OP_PULL;
    if (r < 90) return brbd_pkg::OP_POP;
    if (r < 93) return brbd_pkg::OP_FLUSH;
    if (r < 96) return brbd_pkg::OP_STATUS;
    return brbd_pkg::OP_W'($urandom_range(OP_CODES - 1, int'(brbd_pkg::OP_STATUS) + 1));
  endfunction

  function automatic logic [brbd_pkg::CAP_W-1:0] pick_capacity();
    case ($urandom_range(4))
      0: return '0;
      1: return brbd_pkg::CAP_W'(1);
      2: return brbd_pkg::CAP_W'($urandom_range(2, 16));
      3: return brbd_pkg::CAP_W'($urandom_range(RING_DEPTH + 1, 2 ** brbd_pkg::CAP_W - 1));
      default: return brbd_pkg::CAP_W'($urandom_range(17, RING_DEPTH));
    endcase
  endfunction

  task automatic run_random(int n, int push_pct);
    repeat (n) send_item(pick_op(push_pct), brbd_pkg::BYTE_W'($urandom_range(255)));
  endtask

  task automatic test_empty_after_reset();
    send_item(brbd_pkg::OP_STATUS, 8'hFF);
    send_item(brbd_pkg::OP_PULL, 8'h00);
    send_item(brbd_pkg::OP_POP, 8'hFF);
    for (int c = int'(brbd_pkg::OP_STATUS) + 1; c < OP_CODES; c++) begin
      send_item(brbd_pkg::OP_W'(c), 8'h55);
    end
  endtask

  task automatic test_small_ring();
    write_capacity(brbd_pkg::CAP_W'(3));
    send_item(brbd_pkg::OP_PUSH, 8'h00);
    send_item(brbd_pkg::OP_PUSH, 8'hFF);
    send_item(brbd_pkg::OP_PUSH, 8'hA5);
    send_item(brbd_pkg::OP_PUSH, 8'h5A);
    send_item(brbd_pkg::OP_PULL, 8'h00);
    send_item(brbd_pkg::OP_PUSH, 8'h3C);
    send_item(brbd_pkg::OP_POP, 8'h00);
    send_item(brbd_pkg::OP_POP, 8'h00);
    send_item(brbd_pkg::OP_PULL, 8'h00);
    send_item(brbd_pkg::OP_POP, 8'h00);
    send_item(brbd_pkg::OP_PUSH, 8'h81);
    send_item(brbd_pkg::OP_FLUSH, 8'hFF);
    send_item(brbd_pkg::OP_STATUS, 8'h00);
  endtask

  task automatic test_capacity_clamp();
    // zero acts as one cell
    write_capacity('0);
    send_item(brbd_pkg::OP_PUSH, 8'h11);
    send_item(brbd_pkg::OP_PUSH, 8'h22);
    send_item(brbd_pkg::OP_PULL, 8'h00);
    send_item(brbd_pkg::OP_POP, 8'h00);
    // beyond the storage acts as full depth
    write_capacity('1);
    send_item(brbd_pkg::OP_STATUS, 8'h00);
    write_capacity(brbd_pkg::CAP_W'(RING_DEPTH + 1));
    send_item(brbd_pkg::OP_PUSH, 8'h7E);
    send_item(brbd_pkg::OP_POP, 8'h00);
  endtask

  task automatic test_fill_under_hold_off();
    in_idle_pct   = 0;
    out_stall_pct = 0;
    write_capacity(brbd_pkg::CAP_W'(RING_DEPTH));
    hold_off_req = 1'b1;
    run_random(300, 100);
    // sender pauses until the buffer side is quiet
    wait_results_drained();
    run_random(300, 0);
  endtask

  task automatic test_random_phase(int idle_pct, int stall_pct);
    in_idle_pct   = idle_pct;
    out_stall_pct = stall_pct;
    repeat (3) begin
      write_capacity(pick_capacity());
      repeat (3) run_random(25, $urandom_range(1) ? 85 : 20);
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_empty_after_reset();
    test_small_ring();
    test_capacity_clamp();
    test_fill_under_hold_off();
    test_random_phase(0, 0);
    test_random_phase(50, 0);
    test_random_phase(0, 50);
    test_random_phase(6, 6);
    wait_results_drained();
    repeat (4) @(negedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: byte_ring_buffer_deque.f
rtl/brbd_pkg.sv
rtl/brbd_ram.sv
rtl/byte_ring_buffer_deque.sv
sim/testbench.sv
